// ===== rtl/wfa_pkg.sv =====
// Shared types, constants and helpers for the window function block.
// No dependencies; every rtl file imports it.
package wfa_pkg;

    // Sizes
    localparam int MAX_BLOCK      = 4096;
    localparam int COS_TABLE_BITS = 10;
    localparam int ROM_STEPS      = 1 << COS_TABLE_BITS;
    localparam int ROM_AW         = COS_TABLE_BITS + 1;
    localparam int IDX_W          = $clog2(MAX_BLOCK);
    localparam int LEN_W          = IDX_W + 1;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int WTYPE_W    = 2;
    localparam int BLKLEN_W   = 13;
    localparam int PHASE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd2;

    // Window shapes
    localparam logic [WTYPE_W-1:0] WIN_BOXCAR   = 2'd0;
    localparam logic [WTYPE_W-1:0] WIN_HAMMING  = 2'd1;
    localparam logic [WTYPE_W-1:0] WIN_BLACKMAN = 2'd2;

    // Reset values
    localparam logic [WTYPE_W-1:0]  WTYPE_RST  = WIN_HAMMING;
    localparam logic [BLKLEN_W-1:0] BLKLEN_RST = 13'd1024;
    localparam logic [PHASE_W-1:0]  PSTEP_RST  = 32'd4198404;

    // Q1.17 arithmetic
    localparam int FRAC_BITS  = 17;
    localparam int Q17_ONE    = 131072;
    localparam int ROUND_HALF = 65536;
    localparam int HAM_A0     = 70779;
    localparam int HAM_A1     = 60293;
    localparam int BLK_A0     = 55050;
    localparam int BLK_A1     = 65536;
    localparam int BLK_A2     = 10486;

    // One quarter-wave lookup: ROM address and sign of the result
    typedef struct packed {
        logic [ROM_AW-1:0] addr;
        logic              neg;
    } cos_lookup_t;

    // Round the phase to the table grid and fold it into the first quadrant
    function automatic cos_lookup_t cos_lookup(input logic [PHASE_W-1:0] p);
        logic [COS_TABLE_BITS+2:0]   top_bits;
        logic [COS_TABLE_BITS+3:0]   rnd;
        logic [COS_TABLE_BITS+1:0]   idx;
        logic [1:0]                  quad;
        logic [COS_TABLE_BITS-1:0]   off;
        cos_lookup_t                 res;
        top_bits = p[PHASE_W-1:29-COS_TABLE_BITS];
        rnd      = {1'b0, top_bits} + (COS_TABLE_BITS+4)'(1);
        idx      = rnd[COS_TABLE_BITS+2:1];
        quad     = idx[COS_TABLE_BITS+1:COS_TABLE_BITS];
        off      = idx[COS_TABLE_BITS-1:0];
        res.addr = quad[0] ? (ROM_AW'(ROM_STEPS) - {1'b0, off}) : {1'b0, off};
        res.neg  = quad[0] ^ quad[1];
        return res;
    endfunction

endpackage

// ===== rtl/wfa_cos_rom.sv =====
// Quarter-wave cosine ROM, Q1.17, two registered read ports.
// Depends on wfa_pkg; contents are built at elaboration from a Taylor series.
module wfa_cos_rom
    import wfa_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ROM_AW-1:0] addr_a,
    input  logic [ROM_AW-1:0] addr_b,
    output logic [COEF_W-1:0] data_a,
    output logic [COEF_W-1:0] data_b
);

    typedef logic [COEF_W-1:0] cos_rom_t [0:ROM_STEPS];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Build cos(pi/2 * k / ROM_STEPS): angle in Q2.30, terms truncated
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] term;
        logic signed [63:0] acc;
        for (int k = 0; k <= ROM_STEPS; k++) begin
            theta = (64'(k) * HALF_PI_Q30 + 64'(ROM_STEPS / 2)) >> COS_TABLE_BITS;
            t2    = (theta * theta) >> 30;
            term  = 64'd1 << 30;
            acc   = signed'(term);
            term  = ((term * t2) >> 30) / 2;    acc = acc - signed'(term);
            term  = ((term * t2) >> 30) / 12;   acc = acc + signed'(term);
            term  = ((term * t2) >> 30) / 30;   acc = acc - signed'(term);
            term  = ((term * t2) >> 30) / 56;   acc = acc + signed'(term);
            term  = ((term * t2) >> 30) / 90;   acc = acc - signed'(term);
            term  = ((term * t2) >> 30) / 132;  acc = acc + signed'(term);
            term  = ((term * t2) >> 30) / 182;  acc = acc - signed'(term);
            term  = ((term * t2) >> 30) / 240;  acc = acc + signed'(term);
            term  = ((term * t2) >> 30) / 306;  acc = acc - signed'(term);
            if (acc > 0) begin
                rom[k] = COEF_W'((acc + 64'sd4096) >>> 13);
            end else begin
                rom[k] = '0;
            end
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    // Read both ports; hold the data while the stage stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a <= COS_ROM[addr_a];
            data_b <= COS_ROM[addr_b];
        end
    end

endmodule

// ===== rtl/wfa_coef_calc.sv =====
// Window coefficient datapath: constant multiplies, weighted sum, round, clamp.
// Depends on wfa_pkg; fed by wfa_cos_rom.
module wfa_coef_calc
    import wfa_pkg::*;
(
    input  logic               aclk,
    input  logic               en_mul,
    input  logic               en_sum,
    input  logic [WTYPE_W-1:0] window_type,
    input  logic [COEF_W-1:0]  cos1_mag,
    input  logic               cos1_neg,
    input  logic [COEF_W-1:0]  cos2_mag,
    input  logic               cos2_neg,
    output logic [COEF_W-1:0]  weight
);

    localparam int ACC_W = 38;
    localparam int RND_W = ACC_W - FRAC_BITS;

    logic signed [COEF_W:0]   cos1_s;
    logic signed [COEF_W:0]   cos2_s;
    logic signed [17:0]       k1;
    logic signed [ACC_W-1:0]  prod1_next;
    logic signed [ACC_W-1:0]  prod2_next;
    logic signed [ACC_W-1:0]  prod1_reg;
    logic signed [ACC_W-1:0]  prod2_reg;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc;
    logic signed [RND_W-1:0]  rnd;
    logic [COEF_W-1:0]        weight_next;
    logic [COEF_W-1:0]        weight_reg;

    // Apply the quadrant sign and multiply by the shape constants
    always_comb begin
        cos1_s = cos1_neg ? -signed'({1'b0, cos1_mag}) : signed'({1'b0, cos1_mag});
        cos2_s = cos2_neg ? -signed'({1'b0, cos2_mag}) : signed'({1'b0, cos2_mag});
        k1     = (window_type == WIN_BLACKMAN) ? 18'sd65536 : 18'sd60293;
        prod1_next = ACC_W'(k1) * ACC_W'(cos1_s);
        if (window_type == WIN_BLACKMAN) begin
            prod2_next = ACC_W'(18'sd10486) * ACC_W'(cos2_s);
        end else begin
            prod2_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
    end

    // Sum, round half up to Q1.17 and clamp to [0, 1.0]; other window codes give 1.0
    always_comb begin
        if (window_type == WIN_BLACKMAN) begin
            base = ACC_W'(BLK_A0) <<< FRAC_BITS;
        end else begin
            base = ACC_W'(HAM_A0) <<< FRAC_BITS;
        end
        acc = base - prod1_reg + prod2_reg + ACC_W'(ROUND_HALF);
        rnd = RND_W'(acc >>> FRAC_BITS);
        if (window_type != WIN_HAMMING && window_type != WIN_BLACKMAN) begin
            weight_next = COEF_W'(Q17_ONE);
        end else if (rnd < 0) begin
            weight_next = '0;
        end else if (rnd > RND_W'(Q17_ONE)) begin
            weight_next = COEF_W'(Q17_ONE);
        end else begin
            weight_next = COEF_W'(rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_sum) begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

// ===== rtl/wfa_scale_sat.sv =====
// Sample scaling: I and Q times the coefficient, round half up, saturate.
// Depends on wfa_pkg; takes the coefficient from wfa_coef_calc.
module wfa_scale_sat
    import wfa_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en_mul,
    input  logic                       en_out,
    input  logic signed [SAMPLE_W-1:0] sample_i,
    input  logic signed [SAMPLE_W-1:0] sample_q,
    input  logic [COEF_W-1:0]          weight,
    output logic signed [SAMPLE_W-1:0] out_i,
    output logic signed [SAMPLE_W-1:0] out_q
);

    localparam int PROD_W = SAMPLE_W + COEF_W + 1;
    localparam int RND_W  = PROD_W + 1 - FRAC_BITS;

    logic signed [COEF_W:0]       w_s;
    logic signed [PROD_W-1:0]     prod_i_reg;
    logic signed [PROD_W-1:0]     prod_q_reg;
    logic signed [SAMPLE_W-1:0]   out_i_next;
    logic signed [SAMPLE_W-1:0]   out_q_next;
    logic signed [SAMPLE_W-1:0]   out_i_reg;
    logic signed [SAMPLE_W-1:0]   out_q_reg;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W:0]  biased;
        logic signed [RND_W-1:0] r;
        logic signed [SAMPLE_W-1:0] res;
        biased = (PROD_W+1)'(p) + (PROD_W+1)'(ROUND_HALF);
        r      = RND_W'(biased >>> FRAC_BITS);
        if (r > RND_W'(32767)) begin
            res = 16'sh7FFF;
        end else if (r < -RND_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = SAMPLE_W'(r);
        end
        return res;
    endfunction

    assign w_s = signed'({1'b0, weight});

    // Multiply both parts by the coefficient
    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_i_reg <= PROD_W'(sample_i) * PROD_W'(w_s);
            prod_q_reg <= PROD_W'(sample_q) * PROD_W'(w_s);
        end
    end

    // Round and saturate into the output register
    always_comb begin
        out_i_next = round_sat(prod_i_reg);
        out_q_next = round_sat(prod_q_reg);
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_i_reg <= out_i_next;
            out_q_reg <= out_q_next;
        end
    end

    assign out_i = out_i_reg;
    assign out_q = out_q_reg;

endmodule

// ===== rtl/window_function_apply.sv =====
// Top level of the window function block: config registers, phase/index state,
// pipeline control. Depends on wfa_pkg, wfa_cos_rom, wfa_coef_calc, wfa_scale_sat.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_sample_i, s_sample_q
//   m_        out        m_valid / m_ready    m_out_i, m_out_q, m_last
//   cfg_      in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// One word per cycle sustained while m_ready is high. The rate is set by the
// phase/index update and the two-port cosine ROM read, with one multiplier stage
// for the coefficient and one for the product. Each stage loads when it is empty
// or its word moves on, so bubbles close up under an output stall. Reset is
// synchronous (aresetn low): empties the pipeline, zeros index and phase,
// restores the registers.
module window_function_apply
    import wfa_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_i,
    input  logic signed [SAMPLE_W-1:0] s_sample_q,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_i,
    output logic signed [SAMPLE_W-1:0] m_out_q,
    output logic                       m_last,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int STAGES = 5;

    // Configuration registers
    logic [WTYPE_W-1:0]  window_type_reg;
    logic [BLKLEN_W-1:0] block_length_reg;
    logic [PHASE_W-1:0]  phase_step_reg;

    // Block state
    logic [IDX_W-1:0]    sample_index_reg;
    logic [IDX_W-1:0]    sample_index_next;
    logic [PHASE_W-1:0]  phase_acc_reg;
    logic [PHASE_W-1:0]  phase_acc_next;
    logic [LEN_W-1:0]    len_eff;
    logic                is_last;
    logic                accept;

    // Pipeline control, stage 1 is the ROM read, stage 5 the output register
    logic [STAGES:1]     valid_reg;
    logic [STAGES:1]     last_reg;
    logic [STAGES:1]     en;

    // Payload carried alongside the datapath
    logic signed [SAMPLE_W-1:0] si_reg [1:3];
    logic signed [SAMPLE_W-1:0] sq_reg [1:3];
    cos_lookup_t         look1;
    cos_lookup_t         look2;
    logic                neg1_reg;
    logic                neg2_reg;
    logic [COEF_W-1:0]   cos1;
    logic [COEF_W-1:0]   cos2;
    logic [COEF_W-1:0]   weight;

    // Stage enables: load when this stage is empty or its word moves on
    always_comb begin
        en[STAGES] = !valid_reg[STAGES] || m_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[1];
    assign accept  = s_valid && s_ready;

    // Effective block length and end-of-block test
    always_comb begin
        if (block_length_reg < BLKLEN_W'(2)) begin
            len_eff = LEN_W'(2);
        end else if (32'(block_length_reg) > 32'(MAX_BLOCK)) begin
            len_eff = LEN_W'(MAX_BLOCK);
        end else begin
            len_eff = LEN_W'(block_length_reg);
        end
        is_last = ({1'b0, sample_index_reg} + LEN_W'(1)) >= len_eff;
        if (is_last) begin
            sample_index_next = '0;
            phase_acc_next    = '0;
        end else begin
            sample_index_next = sample_index_reg + IDX_W'(1);
            phase_acc_next    = phase_acc_reg + phase_step_reg;
        end
    end

    // Fold phase and doubled phase into ROM addresses
    always_comb begin
        look1 = cos_lookup(phase_acc_reg);
        look2 = cos_lookup({phase_acc_reg[PHASE_W-2:0], 1'b0});
    end

    // Config registers, block state and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_type_reg  <= WTYPE_RST;
            block_length_reg <= BLKLEN_RST;
            phase_step_reg   <= PSTEP_RST;
            sample_index_reg <= '0;
            phase_acc_reg    <= '0;
            valid_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_WINDOW_TYPE:  window_type_reg  <= cfg_wr_data[WTYPE_W-1:0];
                    REG_BLOCK_LENGTH: block_length_reg <= cfg_wr_data[BLKLEN_W-1:0];
                    REG_PHASE_STEP:   phase_step_reg   <= cfg_wr_data[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                sample_index_reg <= sample_index_next;
                phase_acc_reg    <= phase_acc_next;
            end
            if (en[1]) begin
                valid_reg[1] <= s_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Carry samples, signs and the last flag down the pipeline
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            si_reg[1]   <= s_sample_i;
            sq_reg[1]   <= s_sample_q;
            neg1_reg    <= look1.neg;
            neg2_reg    <= look2.neg;
            last_reg[1] <= is_last;
        end
        for (int k = 2; k <= 3; k++) begin
            if (en[k]) begin
                si_reg[k] <= si_reg[k-1];
                sq_reg[k] <= sq_reg[k-1];
            end
        end
        for (int k = 2; k <= STAGES; k++) begin
            if (en[k]) begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    wfa_cos_rom u_rom (
        .aclk   (aclk),
        .rd_en  (en[1]),
        .addr_a (look1.addr),
        .addr_b (look2.addr),
        .data_a (cos1),
        .data_b (cos2)
    );

    wfa_coef_calc u_coef (
        .aclk        (aclk),
        .en_mul      (en[2]),
        .en_sum      (en[3]),
        .window_type (window_type_reg),
        .cos1_mag    (cos1),
        .cos1_neg    (neg1_reg),
        .cos2_mag    (cos2),
        .cos2_neg    (neg2_reg),
        .weight      (weight)
    );

    wfa_scale_sat u_scale (
        .aclk     (aclk),
        .en_mul   (en[4]),
        .en_out   (en[5]),
        .sample_i (si_reg[3]),
        .sample_q (sq_reg[3]),
        .weight   (weight),
        .out_i    (m_out_i),
        .out_q    (m_out_q)
    );

    assign m_valid = valid_reg[STAGES];
    assign m_last  = last_reg[STAGES];

    // End of block returns index and phase to zero
    a_block_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_last) |=> (sample_index_reg == '0 && phase_acc_reg == '0))
        else $error("index or phase not cleared after last word");

    // Inside a block the index steps by one per accepted word
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_last) |=> (sample_index_reg == $past(sample_index_reg) + IDX_W'(1)))
        else $error("sample index did not advance");

    // Input is held off only when every stage holds a word
    a_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (valid_reg == '1))
        else $error("input stalled with a bubble in the pipeline");

    // Coefficient entering the product stage stays within [0, 1.0]
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[3] |-> (weight <= COEF_W'(Q17_ONE)))
        else $error("window coefficient out of range");

    // Index never reaches the effective block length
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> ({1'b0, sample_index_reg} < len_eff))
        else $error("sample index beyond block length");

endmodule

// ===== test/window_function_apply_tb.sv =====
// Self-checking testbench for window_function_apply: drives random and directed sample
// words, predicts the windowed output word by word and compares it at the result port.
// Depends on wfa_pkg and the window_function_apply RTL.
`timescale 1ns / 100ps

module window_function_apply_tb;
    import wfa_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_i;
        logic signed [SAMPLE_W-1:0] out_q;
        logic                       last;
    } win_word_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam u64_t   QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint SAT_MAX          = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_MIN          = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam int     PIPE_LATENCY     = 5;
    localparam int     HOLD_CYCLES      = 150;
    localparam int     SHAPE_LEN        = 5;
    localparam int     LONG_ITEMS       = 96;
    localparam int     RANDOM_ITEMS     = 1200;
    localparam int     CYCLE_LIMIT      = 400000;

    // DUT ports
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_i   = '0;
    logic signed [SAMPLE_W-1:0] s_sample_q   = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_i;
    logic signed [SAMPLE_W-1:0] m_out_q;
    logic                       m_last;
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_wr_index = REG_WINDOW_TYPE;
    logic [CFG_DATA_W-1:0]      cfg_wr_data  = '0;

    // Predictor state: registers, sample index, phase and the cosine table
    logic [WTYPE_W-1:0]  win_type  = WTYPE_RST;
    logic [BLKLEN_W-1:0] blk_len   = BLKLEN_RST;
    logic [PHASE_W-1:0]  phase_inc = PSTEP_RST;
    logic [IDX_W-1:0]    smp_idx   = '0;
    logic [PHASE_W-1:0]  phase_pos = '0;
    int                  cos_table [ROM_STEPS+1];

    win_word_t windowed_words[$];

    // Traffic control
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit rx_hold_req  = 1'b0;
    int rx_hold_left = 0;
    int rx_wait      = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    window_function_apply uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_i   (s_sample_i),
        .s_sample_q   (s_sample_q),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_i      (m_out_i),
        .m_out_q      (m_out_q),
        .m_last       (m_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Build the quarter-wave cosine table: Taylor series in Q2.30, rounded to Q1.17
    initial begin
        u64_t   theta;
        u64_t   t2;
        u64_t   term;
        longint sum;
        for (int k = 0; k <= ROM_STEPS; k++) begin
            theta = (u64_t'(k) * QUARTER_TURN_Q30 + u64_t'(ROM_STEPS >> 1)) >> COS_TABLE_BITS;
            t2    = (theta * theta) >> 30;
            term  = u64_t'(1) << 30;
            sum   = longint'(term);
            for (int n = 1; n <= 9; n++) begin
                term = ((term * t2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            cos_table[k] = (sum > 0) ? int'((sum + 4096) >>> 13) : 0;
        end
    end

    // Round the phase onto the table grid and unfold the quadrant
    function automatic int table_cos(input logic [PHASE_W-1:0] p);
        int unsigned grid;
        int unsigned off;
        logic [1:0]  quad;
        grid = ((p >> (29 - COS_TABLE_BITS)) + 1) >> 1;
        quad = 2'(grid >> COS_TABLE_BITS);
        off  = grid & (ROM_STEPS - 1);
        if (quad[0]) off = ROM_STEPS - off;
        return (quad[0] ^ quad[1]) ? -cos_table[off] : cos_table[off];
    endfunction

    // Window coefficient in Q1.17, clamped to [0, 1.0]
    function automatic int window_coef(input logic [PHASE_W-1:0] p);
        longint acc;
        longint w;
        case (win_type)
            WIN_HAMMING: begin
                acc = (longint'(HAM_A0) <<< FRAC_BITS) - longint'(HAM_A1) * table_cos(p);
            end
            WIN_BLACKMAN: begin
                acc = (longint'(BLK_A0) <<< FRAC_BITS) - longint'(BLK_A1) * table_cos(p)
                    + longint'(BLK_A2) * table_cos({p[PHASE_W-2:0], 1'b0});
            end
            default: return Q17_ONE;
        endcase
        w = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (w < 0) w = 0;
        if (w > Q17_ONE) w = Q17_ONE;
        return int'(w);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_product(
        input logic signed [SAMPLE_W-1:0] s,
        input int                         coef
    );
        longint r;
        r = (longint'(s) * coef + ROUND_HALF) >>> FRAC_BITS;
        if (r > SAT_MAX) r = SAT_MAX;
        if (r < SAT_MIN) r = SAT_MIN;
        return SAMPLE_W'(r);
    endfunction

    // Out-of-range lengths fold into 2..MAX_BLOCK
    function automatic int effective_length(input logic [BLKLEN_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 2) n = 2;
        if (n > MAX_BLOCK) n = MAX_BLOCK;
        return n;
    endfunction

    function automatic logic [PHASE_W-1:0] ideal_step(input int len);
        u64_t d;
        d = u64_t'(len - 1);
        return PHASE_W'(((u64_t'(1) << PHASE_W) + d / 2) / d);
    endfunction

    // Window one sample word and advance index and phase
    function automatic win_word_t apply_window(
        input logic signed [SAMPLE_W-1:0] si,
        input logic signed [SAMPLE_W-1:0] sq
    );
        int        coef;
        win_word_t w;
        coef    = window_coef(phase_pos);
        w.out_i = sat_product(si, coef);
        w.out_q = sat_product(sq, coef);
        w.last  = (int'(smp_idx) + 1 >= effective_length(blk_len));
        if (w.last) begin
            smp_idx   = '0;
            phase_pos = '0;
        end else begin
            smp_idx   = smp_idx + IDX_W'(1);
            phase_pos = phase_pos + phase_inc;
        end
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Offer one sample word, hold it until accepted, then queue its windowed result
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] si,
        input logic signed [SAMPLE_W-1:0] sq
    );
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            if (s_valid) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_sample_i <= si;
        s_sample_q <= sq;
        do @(posedge aclk); while (!s_ready);
        windowed_words.push_back(apply_window(si, sq));
    endtask

    // Drop valid and wait for every queued word to come out
    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (windowed_words.size() != 0) @(posedge aclk);
    endtask

    // Write all three registers, preceded by a write to the unused index
    task automatic set_window(
        input logic [CFG_DATA_W-1:0] wtype_word,
        input logic [CFG_DATA_W-1:0] len_word,
        input logic [CFG_DATA_W-1:0] step_word
    );
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_UNUSED;
        cfg_wr_data  <= $urandom();
        @(posedge aclk);
        cfg_wr_index <= REG_WINDOW_TYPE;
        cfg_wr_data  <= wtype_word;
        @(posedge aclk);
        win_type     = wtype_word[WTYPE_W-1:0];
        cfg_wr_index <= REG_BLOCK_LENGTH;
        cfg_wr_data  <= len_word;
        @(posedge aclk);
        blk_len      = len_word[BLKLEN_W-1:0];
        cfg_wr_index <= REG_PHASE_STEP;
        cfg_wr_data  <= step_word;
        @(posedge aclk);
        phase_inc    = step_word[PHASE_W-1:0];
        cfg_wr_en    <= 1'b0;
    endtask

    // Full-scale words under the reset settings
    task automatic test_reset_settings();
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, {1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, {1'b0, {(SAMPLE_W-1){1'b1}}});
        wait_drained();
    endtask

    // One short block per window code, unused code included
    task automatic test_window_shapes();
        for (int t = 0; t < (1 << WTYPE_W); t++) begin
            set_window(t, SHAPE_LEN, ideal_step(SHAPE_LEN));
            send_sample(16'sh7FFF, 16'sh8000);
            send_sample(16'sh8000, 16'sh7FFF);
            send_sample(16'sh7FFF, 16'sh7FFF);
            send_sample(16'sh8000, 16'sh8000);
            send_sample(16'sh0001, 16'shFFFF);
            wait_drained();
        end
    endtask

    // Lengths 0 and 1 behave as 2
    task automatic test_short_blocks();
        set_window(CFG_DATA_W'(WIN_BOXCAR), 0, ideal_step(2));
        repeat (2) send_sample(rand_sample(), rand_sample());
        wait_drained();
        set_window(CFG_DATA_W'(WIN_HAMMING), 1, ideal_step(2));
        repeat (2) send_sample(rand_sample(), rand_sample());
        wait_drained();
    endtask

    // Shrink the block below the current index: next word ends the block
    task automatic test_length_lowered();
        set_window(CFG_DATA_W'(WIN_HAMMING), 16, ideal_step(16));
        repeat (10) send_sample(rand_sample(), rand_sample());
        wait_drained();
        set_window(CFG_DATA_W'(WIN_BLACKMAN), 6, ideal_step(6));
        repeat (8) send_sample(rand_sample(), rand_sample());
        wait_drained();
    endtask

    // All-ones length clamps to MAX_BLOCK; run a stretch of it without idling
    task automatic test_long_block();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_window(CFG_DATA_W'(WIN_BLACKMAN), CFG_DATA_W'({BLKLEN_W{1'b1}}),
                   ideal_step(MAX_BLOCK));
        repeat (LONG_ITEMS) send_sample(rand_sample(), rand_sample());
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Hold the result side off while words keep coming, so the input stalls
    task automatic test_output_stall();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        set_window(CFG_DATA_W'(WIN_HAMMING), 12, ideal_step(12));
        rx_hold_req = 1'b1;
        repeat (40) send_sample(rand_sample(), rand_sample());
        wait_drained();
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
    endtask

    // Random settings per phase and random word counts, mostly with matching phase steps
    task automatic test_random_blocks();
        int                    sent;
        int                    eff;
        int                    count;
        logic [CFG_DATA_W-1:0] wt;
        logic [CFG_DATA_W-1:0] ln;
        logic [CFG_DATA_W-1:0] st;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wt = CFG_DATA_W'($urandom() & ((1 << WTYPE_W) - 1));
            case ($urandom_range(0, 11))
                0: ln = $urandom_range(0, 1);
                1: ln = $urandom_range(MAX_BLOCK, (1 << BLKLEN_W) - 1);
                2: ln = $urandom_range(41, MAX_BLOCK - 1);
                default: ln = $urandom_range(2, 40);
            endcase
            eff = effective_length(ln[BLKLEN_W-1:0]);
            case ($urandom_range(0, 15))
                0: st = '0;
                1: st = '1;
                2, 3: st = $urandom();
                default: st = ideal_step(eff);
            endcase
            // unused upper data bits must be ignored
            if ($urandom_range(0, 3) == 0) begin
                wt[CFG_DATA_W-1:WTYPE_W] = (CFG_DATA_W-WTYPE_W)'($urandom());
            end
            if ($urandom_range(0, 3) == 0) begin
                ln[CFG_DATA_W-1:BLKLEN_W] = (CFG_DATA_W-BLKLEN_W)'($urandom());
            end
            count      = $urandom_range(1, (eff <= 40) ? 3 * eff : 60);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            set_window(wt, ln, st);
            repeat (count) send_sample(rand_sample(), rand_sample());
            sent += count;
            wait_drained();
        end
    endtask

    // Pace the result side: random wait after each word, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (rx_hold_req) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
                m_ready <= (rx_wait == 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= (rx_wait == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each output word against the oldest prediction
    always @(posedge aclk) begin
        win_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (windowed_words.size() == 0) begin
                $display("%0t: unexpected word i=%0d q=%0d last=%0b",
                         $time, m_out_i, m_out_q, m_last);
                error_count++;
            end else begin
                exp_w = windowed_words.pop_front();
                if (m_out_i !== exp_w.out_i) begin
                    $display("%0t: out_i expected %0d actual %0d", $time, exp_w.out_i, m_out_i);
                    error_count++;
                end
                if (m_out_q !== exp_w.out_q) begin
                    $display("%0t: out_q expected %0d actual %0d", $time, exp_w.out_q, m_out_q);
                    error_count++;
                end
                if (m_last !== exp_w.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, exp_w.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("window_function_apply_tb NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_settings();
        test_window_shapes();
        test_short_blocks();
        test_length_lowered();
        test_long_block();
        test_output_stall();
        test_random_blocks();
        wait_drained();
        // let any stray word show up
        repeat (PIPE_LATENCY * 4) @(posedge aclk);
        if (error_count == 0 && windowed_words.size() == 0) begin
            $display("window_function_apply_tb OK");
        end else begin
            $display("window_function_apply_tb NOT OK");
        end
        $finish;
    end

endmodule
